// ----- rtl/core/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, register indexes and defaults of the scan frame averager.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int RANGE_W      = 16;
    localparam int OBEAMS_W     = 11;
    localparam int CFRAMES_W    = 12;
    localparam int CVAL_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_MAX_BEAMS = 1024;
    localparam int DEF_WINDOW    = 10;

    localparam logic [OBEAMS_W-1:0]  RST_OUTPUT_BEAMS = OBEAMS_W'(521);
    localparam logic [CFRAMES_W-1:0] RST_CLEAR_FRAMES = CFRAMES_W'(500);
    localparam logic [CVAL_W-1:0]    RST_CLEAR_VALUE  = CVAL_W'(15000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_BEAMS = 2'd0,
        CFG_CLEAR_FRAMES = 2'd1,
        CFG_CLEAR_VALUE  = 2'd2
    } cfg_reg_t;

endpackage

// ----- rtl/core/sfa_in_if.sv -----
// ----------------------------------------------------------------------------
// sfa_in_if
// Beam input channel: valid/ready with range and frame flags.
// ----------------------------------------------------------------------------
interface sfa_in_if import sfa_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               last_beam;
    logic               obstacle_mode;

    modport source (output valid, output range_mm, output last_beam,
                    output obstacle_mode, input ready);
    modport sink   (input valid, input range_mm, input last_beam,
                    input obstacle_mode, output ready);

endinterface

// ----- rtl/core/sfa_out_if.sv -----
// ----------------------------------------------------------------------------
// sfa_out_if
// Averaged beam output channel: valid/ready with range and status flags.
// ----------------------------------------------------------------------------
interface sfa_out_if import sfa_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_out;
    logic               clear_active;
    logic               frame_end;

    modport source (output valid, output range_out, output clear_active,
                    output frame_end, input ready);
    modport sink   (input valid, input range_out, input clear_active,
                    input frame_end, output ready);

endinterface

// ----- rtl/core/scan_frame_average_with_clear.sv -----
// ----------------------------------------------------------------------------
// scan_frame_average_with_clear
// Per-beam moving average over the last WINDOW frames, with clearing runs.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beam passes stage 1, stage 2 and the output register.
// Throughput: one beam per cycle unless beam_out stalls; history and running-sum
//   memories take a read and a write each per cycle, same-beam hazard forwarded.
// Reset: control state clears at once; memories are not cleared, per-slot
//   fill counts mask entries never written, so no clearing pass is needed.
module scan_frame_average_with_clear import sfa_pkg::*; #(
    parameter int MAX_BEAMS = DEF_MAX_BEAMS,
    parameter int WINDOW    = DEF_WINDOW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sfa_in_if.sink                beam_in,
    sfa_out_if.source             beam_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BW     = $clog2(MAX_BEAMS + 1);
    localparam int AW     = $clog2(MAX_BEAMS);
    localparam int SW     = $clog2(WINDOW);
    localparam int FW     = $clog2(WINDOW + 2);
    localparam int HDEPTH = WINDOW * MAX_BEAMS;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int SUM_W  = $clog2(WINDOW * 65536);
    localparam int CMPW   = ((BW > OBEAMS_W) ? BW : OBEAMS_W) + 1;
    localparam logic [FW-1:0]   START_C = FW'(WINDOW + 1);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [BW-1:0]   MAXB_B  = BW'(MAX_BEAMS);
    localparam logic [CMPW-1:0] MAXB_C  = CMPW'(MAX_BEAMS);
    localparam logic [HAW-1:0]  MAXB_H  = HAW'(MAX_BEAMS);

    // configuration
    logic [OBEAMS_W-1:0]  obeams_reg;
    logic [CFRAMES_W-1:0] cframes_reg;
    logic [CVAL_W-1:0]    cval_reg;

    // frame control
    logic [BW-1:0]        beam_reg,    beam_next;
    logic [SW-1:0]        slot_reg,    slot_next;
    logic [FW-1:0]        frames_reg,  frames_next;
    logic                 fmode_reg,   fmode_next;
    logic                 pmode_reg,   pmode_next;
    logic                 clr_reg,     clr_next;
    logic [CFRAMES_W-1:0] ccnt_reg,    ccnt_next;
    logic [BW-1:0]        fill_reg [WINDOW];
    logic [BW-1:0]        hw_reg;

    // stage 1: memory data back
    logic                 s1_v_reg;
    logic [AW-1:0]        s1_beam_reg;
    logic [HAW-1:0]       s1_haddr_reg;
    logic [RANGE_W-1:0]   s1_range_reg;
    logic                 s1_old_ok_reg, s1_sum_ok_reg, s1_store_reg, s1_out_reg;
    logic                 s1_clr_reg, s1_fend_reg;
    logic [CVAL_W-1:0]    s1_cval_reg;
    logic [RANGE_W-1:0]   hist_rd_reg;
    logic [SUM_W-1:0]     sum_rd_reg;

    // last running-sum write, for the single-beam-frame hazard
    logic                 fw_v_reg;
    logic [AW-1:0]        fw_beam_reg;
    logic [SUM_W-1:0]     fw_sum_reg;

    // stage 2: window sum
    logic                 s2_v_reg;
    logic [SUM_W-1:0]     s2_sum_reg;
    logic                 s2_clr_reg, s2_fend_reg;
    logic [CVAL_W-1:0]    s2_cval_reg;

    // output register
    logic                 out_v_reg;
    logic [RANGE_W-1:0]   out_range_reg;
    logic                 out_clr_reg, out_fend_reg;

    logic [RANGE_W-1:0]   hist_mem [HDEPTH];
    logic [SUM_W-1:0]     sum_mem  [MAX_BEAMS];

    logic                 out_adv, s2_adv, s1_adv, acc, s1_wr;
    logic                 active, first, clr_cur, store, has_out, fend;
    logic                 old_ok, sum_ok;
    logic [CMPW-1:0]      count, beam_c;
    logic [AW-1:0]        beam_a;
    logic [HAW-1:0]       haddr;
    logic [CFRAMES_W-1:0] ccnt_inc;
    logic [BW-1:0]        fill_cur;
    logic [SUM_W-1:0]     sum_eff, old_val, new_sum;
    logic [RANGE_W-1:0]   mean;

    assign out_adv = !out_v_reg || beam_out.ready;
    assign s2_adv  = !s2_v_reg || out_adv;
    assign s1_adv  = !s1_v_reg || s2_adv;
    assign beam_in.ready = s1_adv;
    assign acc     = beam_in.valid && s1_adv;
    assign s1_wr   = s1_v_reg && s2_adv && s1_store_reg;

    // ---------------- stage 0: frame bookkeeping ----------------
    always_comb
    begin
        active   = frames_reg >= START_C;
        first    = beam_reg == '0;
        store    = beam_reg != MAXB_B;
        beam_a   = beam_reg[AW-1:0];
        haddr    = HAW'(slot_reg) * MAXB_H + HAW'(beam_a);
        count    = (CMPW'(obeams_reg) > MAXB_C) ? MAXB_C : CMPW'(obeams_reg);
        beam_c   = CMPW'(beam_reg);
        has_out  = active && (beam_c < count);
        fend     = beam_in.last_beam || (beam_c + CMPW'(1) == count);
        fill_cur = fill_reg[slot_reg];
        old_ok   = beam_reg < fill_cur;
        sum_ok   = beam_reg < hw_reg;
        clr_cur  = clr_reg || (first && active && pmode_reg && !beam_in.obstacle_mode);
        ccnt_inc = ccnt_reg + CFRAMES_W'(1);

        beam_next   = beam_reg;
        slot_next   = slot_reg;
        frames_next = frames_reg;
        fmode_next  = first ? beam_in.obstacle_mode : fmode_reg;
        pmode_next  = pmode_reg;
        clr_next    = clr_cur;
        ccnt_next   = ccnt_reg;

        if (beam_in.last_beam)
        begin
            if (active && clr_cur)
            begin
                if (ccnt_inc == cframes_reg)
                begin
                    clr_next  = 1'b0;
                    ccnt_next = '0;
                end
                else
                begin
                    ccnt_next = ccnt_inc;
                end
            end
            pmode_next = fmode_next;
            if (frames_reg < START_C)
                frames_next = frames_reg + FW'(1);
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SW'(1);
            beam_next = '0;
        end
        else if (store)
        begin
            beam_next = beam_reg + BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obeams_reg  <= RST_OUTPUT_BEAMS;
            cframes_reg <= RST_CLEAR_FRAMES;
            cval_reg    <= RST_CLEAR_VALUE;
            beam_reg    <= '0;
            slot_reg    <= '0;
            frames_reg  <= '0;
            fmode_reg   <= 1'b0;
            pmode_reg   <= 1'b0;
            clr_reg     <= 1'b0;
            ccnt_reg    <= '0;
            hw_reg      <= '0;
            for (int i = 0; i < WINDOW; i++)
                fill_reg[i] <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            fw_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OUTPUT_BEAMS: obeams_reg  <= cfg_data[OBEAMS_W-1:0];
                    CFG_CLEAR_FRAMES: cframes_reg <= cfg_data[CFRAMES_W-1:0];
                    CFG_CLEAR_VALUE:  cval_reg    <= cfg_data[CVAL_W-1:0];
                    default: ;
                endcase
            end
            if (acc)
            begin
                beam_reg   <= beam_next;
                slot_reg   <= slot_next;
                frames_reg <= frames_next;
                fmode_reg  <= fmode_next;
                pmode_reg  <= pmode_next;
                clr_reg    <= clr_next;
                ccnt_reg   <= ccnt_next;
                if (store && !old_ok)
                    fill_reg[slot_reg] <= beam_reg + BW'(1);
                if (store && !sum_ok)
                    hw_reg <= beam_reg + BW'(1);
            end
            if (s1_adv)
                s1_v_reg <= acc;
            if (s2_adv)
                s2_v_reg <= s1_v_reg && s1_out_reg;
            if (out_adv)
                out_v_reg <= s2_v_reg;
            if (s1_wr)
                fw_v_reg <= 1'b1;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_beam_reg   <= beam_a;
            s1_haddr_reg  <= haddr;
            s1_range_reg  <= beam_in.range_mm;
            s1_old_ok_reg <= old_ok;
            s1_sum_ok_reg <= sum_ok;
            s1_store_reg  <= store;
            s1_out_reg    <= has_out;
            s1_clr_reg    <= clr_cur;
            s1_fend_reg   <= fend;
            s1_cval_reg   <= cval_reg;
        end
        if (s1_wr)
        begin
            fw_beam_reg <= s1_beam_reg;
            fw_sum_reg  <= new_sum;
        end
        if (s2_adv)
        begin
            s2_sum_reg  <= new_sum;
            s2_clr_reg  <= s1_clr_reg;
            s2_fend_reg <= s1_fend_reg;
            s2_cval_reg <= s1_cval_reg;
        end
        if (out_adv)
        begin
            out_range_reg <= s2_clr_reg ? s2_cval_reg : mean;
            out_clr_reg   <= s2_clr_reg;
            out_fend_reg  <= s2_fend_reg;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            hist_rd_reg <= hist_mem[haddr];
            sum_rd_reg  <= sum_mem[beam_a];
        end
        if (s1_wr)
        begin
            hist_mem[s1_haddr_reg] <= s1_range_reg;
            sum_mem[s1_beam_reg]   <= new_sum;
        end
    end

    // ---------------- stage 1: update running sum ----------------
    always_comb
    begin
        if (fw_v_reg && fw_beam_reg == s1_beam_reg)
            sum_eff = fw_sum_reg;
        else if (s1_sum_ok_reg)
            sum_eff = sum_rd_reg;
        else
            sum_eff = '0;
        old_val = s1_old_ok_reg ? SUM_W'(hist_rd_reg) : '0;
        new_sum = sum_eff - old_val + SUM_W'(s1_range_reg);
    end

    sfa_mean #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_mean (
        .sum  (s2_sum_reg),
        .mean (mean)
    );

    assign beam_out.valid        = out_v_reg;
    assign beam_out.range_out    = out_range_reg;
    assign beam_out.clear_active = out_clr_reg;
    assign beam_out.frame_end    = out_fend_reg;

    // ---------------- assertions ----------------
    a_beam_sat: assert property (@(posedge clk) disable iff (!rst_n)
        beam_reg <= MAXB_B)
        else $error("beam position past saturation");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("history slot out of range");

    a_frames_sat: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= START_C)
        else $error("frame count past saturation");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(s2_v_reg))
        else $error("result appeared without a window sum");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[slot_reg] <= hw_reg)
        else $error("slot fill count above high-water mark");

endmodule

// ----- rtl/core/sfa_mean.sv -----
// ----------------------------------------------------------------------------
// sfa_mean
// Truncated mean of a window sum: multiply by a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module sfa_mean import sfa_pkg::*; #(
    parameter int WINDOW = DEF_WINDOW,
    parameter int SUM_W  = $clog2(DEF_WINDOW * 65536)
) (
    input  logic [SUM_W-1:0]   sum,
    output logic [RANGE_W-1:0] mean
);

    // K = N + ceil(log2 d) makes floor(n * ceil(2^K / d) / 2^K) exact for n < 2^N
    localparam int K     = SUM_W + $clog2(WINDOW);
    localparam int MW    = K + 1;
    localparam int PW    = SUM_W + MW;
    localparam longint RECIP = ((longint'(1) << K) + longint'(WINDOW) - 1)
                               / longint'(WINDOW);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

    logic [PW-1:0] prod;

    assign prod = PW'(sum) * PW'(RECIP_C);
    assign mean = prod[K +: RANGE_W];

endmodule
